// ===== rtl/grs_pkg.sv =====
package grs_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned FrameW = 16;
  localparam int unsigned PhaseW = 16;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;

  // signed working width for bound compares and mirrored positions
  localparam int unsigned CmpW = CoordW + 2;
  localparam int unsigned MirW = CoordW + 3;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [FrameW-1:0] frame_t;
  typedef logic [PhaseW-1:0] phase_bounds_t;

  // input command codes
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  // register map, index = byte address / 4
  typedef enum logic [2:0] {
    REG_X_START        = 3'd0,
    REG_X_LIMIT        = 3'd1,
    REG_Y_START        = 3'd2,
    REG_Y_LIMIT        = 3'd3,
    REG_X_INCREMENT    = 3'd4,
    REG_Y_INCREMENT    = 3'd5,
    REG_X_PHASE_BOUNDS = 3'd6,
    REG_Y_PHASE_BOUNDS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    coord_t        x_start;
    coord_t        x_limit;
    coord_t        y_start;
    coord_t        y_limit;
    coord_t        x_increment;
    coord_t        y_increment;
    phase_bounds_t x_phase_bounds;
    phase_bounds_t y_phase_bounds;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    x_start:        8'd0,
    x_limit:        8'd255,
    y_start:        8'd0,
    y_limit:        8'd255,
    x_increment:    8'd5,
    y_increment:    8'd5,
    x_phase_bounds: 16'h0500,
    y_phase_bounds: 16'h0500
  };

  // scan position state
  typedef struct packed {
    frame_t frames_left;
    coord_t x_phase;
    coord_t y_phase;
    coord_t x_cursor;
    coord_t y_cursor;
    logic   column_odd;
    logic   running;
  } scan_t;

endpackage

// ===== rtl/grs_if.sv =====
interface grs_item_if;
  import grs_pkg::*;

  logic   valid;
  logic   ready;
  logic   cmd;
  frame_t frame_count;

  modport source (output valid, output cmd, output frame_count, input ready);
  modport sink (input valid, input cmd, input frame_count, output ready);
endinterface

interface grs_result_if;
  import grs_pkg::*;

  logic   valid;
  logic   ready;
  coord_t x_pos;
  coord_t y_pos;
  logic   point_valid;
  logic   scan_last;

  modport source (output valid, output x_pos, output y_pos, output point_valid,
                  output scan_last, input ready);
  modport sink (input valid, input x_pos, input y_pos, input point_valid,
                input scan_last, output ready);
endinterface

// ===== rtl/galvo_raster_scan_generator_core.sv =====
// Serpentine raster scan generator for an X/Y mirror pair.
// item_i takes commands: start (cmd = 1) loads frame_count and rewinds the
// scan to the first phase pair and the first column; tick (cmd = 0) emits the
// current point and steps the Y cursor, then the column, then the Y phase,
// then the X phase and finally the frame count.
// result_o gives one transaction per command: x_pos, y_pos, point_valid and
// scan_last, all zero for a start or for a tick while no scan is running.
// The result is registered: the output register takes it on the edge at
// which the command is taken. Throughput is one command per cycle while
// the receiver does not stall, as the cursor state updates per command.
// If the receiver stalls, the output register holds its transaction and
// item_i.ready stays high only while the receiver takes the held result in
// the same cycle.
// The user writes registers through the APB port (byte address 4 * index)
// only while the block is idle, which the block does not enforce. Reset
// loads register defaults, clears scan state: comes up idle, no result pending.
module galvo_raster_scan_generator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [grs_pkg::ApbAddrW-1:0]     paddr,
  input  logic [grs_pkg::ApbDataW-1:0]     pwdata,
  output logic [grs_pkg::ApbDataW-1:0]     prdata,
  output logic                             pready,
  grs_item_if.sink                         item_i,
  grs_result_if.source                     result_o
);
  import grs_pkg::*;

  cfg_t     cfg_q;
  scan_t    scan_q, scan_d;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  logic   out_valid_q;
  coord_t x_pos_q, x_pos_d;
  coord_t y_pos_q, y_pos_d;
  logic   point_valid_q, point_valid_d;
  logic   scan_last_q, scan_last_d;

  logic   item_acc;
  logic   ready;

  logic signed [CmpW-1:0] x_bound;
  logic signed [CmpW-1:0] y_bound;
  logic signed [CmpW-1:0] nx;
  logic signed [CmpW-1:0] ny;
  logic        [CmpW-1:0] xs;
  logic        [CmpW-1:0] ys;
  logic signed [MirW-1:0] y_mir;
  logic        [CoordW:0] nxp;
  logic        [CoordW:0] nyp;
  coord_t x_ph_lo, x_ph_hi, y_ph_lo, y_ph_hi;
  frame_t frames_dec;
  logic   start_ok;

  // apb register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_X_START:        cfg_q.x_start        <= pwdata[CoordW-1:0];
        REG_X_LIMIT:        cfg_q.x_limit        <= pwdata[CoordW-1:0];
        REG_Y_START:        cfg_q.y_start        <= pwdata[CoordW-1:0];
        REG_Y_LIMIT:        cfg_q.y_limit        <= pwdata[CoordW-1:0];
        REG_X_INCREMENT:    cfg_q.x_increment    <= pwdata[CoordW-1:0];
        REG_Y_INCREMENT:    cfg_q.y_increment    <= pwdata[CoordW-1:0];
        REG_X_PHASE_BOUNDS: cfg_q.x_phase_bounds <= pwdata[PhaseW-1:0];
        REG_Y_PHASE_BOUNDS: cfg_q.y_phase_bounds <= pwdata[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_X_START:        prdata = ApbDataW'(cfg_q.x_start);
      REG_X_LIMIT:        prdata = ApbDataW'(cfg_q.x_limit);
      REG_Y_START:        prdata = ApbDataW'(cfg_q.y_start);
      REG_Y_LIMIT:        prdata = ApbDataW'(cfg_q.y_limit);
      REG_X_INCREMENT:    prdata = ApbDataW'(cfg_q.x_increment);
      REG_Y_INCREMENT:    prdata = ApbDataW'(cfg_q.y_increment);
      REG_X_PHASE_BOUNDS: prdata = ApbDataW'(cfg_q.x_phase_bounds);
      REG_Y_PHASE_BOUNDS: prdata = ApbDataW'(cfg_q.y_phase_bounds);
      default:            prdata = '0;
    endcase
  end

  // handshake: accept while the output register is empty or being drained
  assign ready        = ~out_valid_q | result_o.ready;
  assign item_i.ready = ready;
  assign item_acc     = item_i.valid & ready;

  // bounds and step arithmetic
  assign x_ph_lo = cfg_q.x_phase_bounds[CoordW-1:0];
  assign x_ph_hi = cfg_q.x_phase_bounds[PhaseW-1:CoordW];
  assign y_ph_lo = cfg_q.y_phase_bounds[CoordW-1:0];
  assign y_ph_hi = cfg_q.y_phase_bounds[PhaseW-1:CoordW];

  assign x_bound = signed'(CmpW'(cfg_q.x_limit)) - signed'(CmpW'(cfg_q.x_increment));
  assign y_bound = signed'(CmpW'(cfg_q.y_limit)) - signed'(CmpW'(cfg_q.y_increment));
  assign nx      = signed'(CmpW'(scan_q.x_cursor) + CmpW'(cfg_q.x_increment));
  assign ny      = signed'(CmpW'(scan_q.y_cursor) + CmpW'(cfg_q.y_increment));
  assign xs      = CmpW'(scan_q.x_cursor) + CmpW'(scan_q.x_phase);
  assign ys      = CmpW'(scan_q.y_cursor) + CmpW'(scan_q.y_phase);
  assign y_mir   = MirW'(y_bound) - signed'(MirW'(ys));
  assign nxp     = (CoordW+1)'(scan_q.x_phase) + (CoordW+1)'(1);
  assign nyp     = (CoordW+1)'(scan_q.y_phase) + (CoordW+1)'(1);
  assign frames_dec = scan_q.frames_left - FrameW'(1);

  assign start_ok = (item_i.frame_count != '0)
                  && (signed'(CmpW'(cfg_q.x_start)) < x_bound)
                  && (signed'(CmpW'(cfg_q.y_start)) < y_bound)
                  && (x_ph_lo <= x_ph_hi)
                  && (y_ph_lo <= y_ph_hi);

  // next scan state and result
  always_comb begin
    scan_d        = scan_q;
    x_pos_d       = x_pos_q;
    y_pos_d       = y_pos_q;
    point_valid_d = point_valid_q;
    scan_last_d   = scan_last_q;
    if (item_acc) begin
      x_pos_d       = '0;
      y_pos_d       = '0;
      point_valid_d = 1'b0;
      scan_last_d   = 1'b0;
      if (item_i.cmd == CMD_START) begin
        scan_d.x_cursor    = cfg_q.x_start;
        scan_d.y_cursor    = cfg_q.y_start;
        scan_d.x_phase     = x_ph_lo;
        scan_d.y_phase     = y_ph_lo;
        scan_d.column_odd  = 1'b0;
        scan_d.frames_left = item_i.frame_count;
        scan_d.running     = start_ok;
      end else if (scan_q.running) begin
        // emit the current point, saturated to the dac range
        point_valid_d = 1'b1;
        x_pos_d = xs[CoordW] ? '1 : xs[CoordW-1:0];
        if (!scan_q.column_odd) begin
          y_pos_d = ys[CoordW] ? '1 : ys[CoordW-1:0];
        end else begin
          y_pos_d = y_mir[MirW-1] ? '0 : y_mir[CoordW-1:0];
        end
        // step y, then column, then y phase, then x phase, then frame
        if (ny < y_bound) begin
          scan_d.y_cursor = ny[CoordW-1:0];
        end else begin
          scan_d.y_cursor   = cfg_q.y_start;
          scan_d.column_odd = ~scan_q.column_odd;
          if (nx < x_bound) begin
            scan_d.x_cursor = nx[CoordW-1:0];
          end else begin
            scan_d.x_cursor = cfg_q.x_start;
            if (nyp <= (CoordW+1)'(y_ph_hi)) begin
              scan_d.y_phase = nyp[CoordW-1:0];
            end else begin
              scan_d.y_phase = y_ph_lo;
              if (nxp <= (CoordW+1)'(x_ph_hi)) begin
                scan_d.x_phase = nxp[CoordW-1:0];
              end else begin
                scan_d.x_phase     = x_ph_lo;
                scan_d.frames_left = frames_dec;
                if (frames_dec == '0) begin
                  scan_d.running = 1'b0;
                  scan_last_d    = 1'b1;
                end
              end
            end
          end
        end
      end
    end
  end

  // scan state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_acc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    x_pos_q       <= x_pos_d;
    y_pos_q       <= y_pos_d;
    point_valid_q <= point_valid_d;
    scan_last_q   <= scan_last_d;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.x_pos       = x_pos_q;
  assign result_o.y_pos       = y_pos_q;
  assign result_o.point_valid = point_valid_q;
  assign result_o.scan_last   = scan_last_q;

endmodule

// ===== bench/galvo_raster_scan_generator_core_checker.sv =====
module grs_point_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [grs_pkg::ApbAddrW-1:0] paddr,
  input  logic [grs_pkg::ApbDataW-1:0] pwdata,
  input  logic [grs_pkg::ApbDataW-1:0] prdata,
  input  logic                         pready,
  grs_item_if                          item_mon,
  grs_result_if                        point_mon,
  input  logic                         run_done,
  output int unsigned                  mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import grs_pkg::*;

  typedef struct packed {
    coord_t x_pos;
    coord_t y_pos;
    logic   point_valid;
    logic   scan_last;
  } scan_point_t;

  cfg_t        cfg;
  scan_t       st;
  scan_point_t pending_points[$];
  scan_point_t got_point;
  scan_point_t want_point;
  bit          leftover_checked;

  function automatic int x_bound();
    return int'(cfg.x_limit) - int'(cfg.x_increment);
  endfunction

  function automatic int y_bound();
    return int'(cfg.y_limit) - int'(cfg.y_increment);
  endfunction

  function automatic coord_t clamp_dac(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return coord_t'(v);
  endfunction

  // step y, then column, then y phase, then x phase, then frame; 1 when scan ends
  function automatic bit step_cursor();
    int ny;
    int nx;
    int np;
    ny = int'(st.y_cursor) + int'(cfg.y_increment);
    if (ny < y_bound()) begin
      st.y_cursor = coord_t'(ny);
      return 1'b0;
    end
    st.y_cursor   = cfg.y_start;
    st.column_odd = ~st.column_odd;
    nx = int'(st.x_cursor) + int'(cfg.x_increment);
    if (nx < x_bound()) begin
      st.x_cursor = coord_t'(nx);
      return 1'b0;
    end
    st.x_cursor = cfg.x_start;
    np = int'(st.y_phase) + 1;
    if (np <= int'(cfg.y_phase_bounds[15:8])) begin
      st.y_phase = coord_t'(np);
      return 1'b0;
    end
    st.y_phase = cfg.y_phase_bounds[7:0];
    np = int'(st.x_phase) + 1;
    if (np <= int'(cfg.x_phase_bounds[15:8])) begin
      st.x_phase = coord_t'(np);
      return 1'b0;
    end
    st.x_phase     = cfg.x_phase_bounds[7:0];
    st.frames_left = st.frames_left - FrameW'(1);
    return st.frames_left == '0;
  endfunction

  // expected point for one command, updating the scan state
  function automatic scan_point_t predict_point(cmd_e cmd, frame_t frames);
    scan_point_t p;
    int          ys;
    p = '0;
    if (cmd == CMD_START) begin
      st.x_cursor    = cfg.x_start;
      st.y_cursor    = cfg.y_start;
      st.x_phase     = cfg.x_phase_bounds[7:0];
      st.y_phase     = cfg.y_phase_bounds[7:0];
      st.column_odd  = 1'b0;
      st.frames_left = frames;
      st.running     = (frames != '0) &&
                       (int'(cfg.x_start) < x_bound()) &&
                       (int'(cfg.y_start) < y_bound()) &&
                       (cfg.x_phase_bounds[7:0] <= cfg.x_phase_bounds[15:8]) &&
                       (cfg.y_phase_bounds[7:0] <= cfg.y_phase_bounds[15:8]);
      return p;
    end
    if (!st.running) return p;
    ys            = int'(st.y_cursor) + int'(st.y_phase);
    p.x_pos       = clamp_dac(int'(st.x_cursor) + int'(st.x_phase));
    p.y_pos       = st.column_odd ? clamp_dac(y_bound() - ys) : clamp_dac(ys);
    p.point_valid = 1'b1;
    if (step_cursor()) begin
      st.running  = 1'b0;
      p.scan_last = 1'b1;
    end
    return p;
  endfunction

  function automatic logic [ApbDataW-1:0] reg_value(reg_idx_e idx);
    case (idx)
      REG_X_START:        return ApbDataW'(cfg.x_start);
      REG_X_LIMIT:        return ApbDataW'(cfg.x_limit);
      REG_Y_START:        return ApbDataW'(cfg.y_start);
      REG_Y_LIMIT:        return ApbDataW'(cfg.y_limit);
      REG_X_INCREMENT:    return ApbDataW'(cfg.x_increment);
      REG_Y_INCREMENT:    return ApbDataW'(cfg.y_increment);
      REG_X_PHASE_BOUNDS: return ApbDataW'(cfg.x_phase_bounds);
      REG_Y_PHASE_BOUNDS: return ApbDataW'(cfg.y_phase_bounds);
      default:            return '0;
    endcase
  endfunction

  function automatic void store_reg(reg_idx_e idx, logic [ApbDataW-1:0] value);
    case (idx)
      REG_X_START:        cfg.x_start        = value[7:0];
      REG_X_LIMIT:        cfg.x_limit        = value[7:0];
      REG_Y_START:        cfg.y_start        = value[7:0];
      REG_Y_LIMIT:        cfg.y_limit        = value[7:0];
      REG_X_INCREMENT:    cfg.x_increment    = value[7:0];
      REG_Y_INCREMENT:    cfg.y_increment    = value[7:0];
      REG_X_PHASE_BOUNDS: cfg.x_phase_bounds = value[15:0];
      REG_Y_PHASE_BOUNDS: cfg.y_phase_bounds = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // watch register port and both channels; results are matched before new commands
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg              = CfgReset;
      st               = '0;
      mismatch_count   = 0;
      leftover_checked = 1'b0;
      pending_points.delete();
    end else begin
      // result transaction against the oldest expectation
      if (point_mon.valid && point_mon.ready) begin
        got_point = '{x_pos: point_mon.x_pos, y_pos: point_mon.y_pos,
                      point_valid: point_mon.point_valid,
                      scan_last: point_mon.scan_last};
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual x %0d y %0d pv %0b last %0b",
                   $time, got_point.x_pos, got_point.y_pos, got_point.point_valid,
                   got_point.scan_last);
          mismatch_count++;
        end else begin
          want_point = pending_points.pop_front();
          check_field("x_pos", want_point.x_pos, got_point.x_pos);
          check_field("y_pos", want_point.y_pos, got_point.y_pos);
          check_field("point_valid", want_point.point_valid, got_point.point_valid);
          check_field("scan_last", want_point.scan_last, got_point.scan_last);
        end
      end

      // register access phase
      if (psel && penable && pready) begin
        if (pwrite) begin
          store_reg(reg_idx_e'(paddr[ApbAddrW-1:2]), pwdata);
        end else if (prdata != reg_value(reg_idx_e'(paddr[ApbAddrW-1:2]))) begin
          $display("%0t: register %0d readback, expected %0h, actual %0h", $time,
                   paddr[ApbAddrW-1:2], reg_value(reg_idx_e'(paddr[ApbAddrW-1:2])), prdata);
          mismatch_count++;
        end
      end

      // command transaction
      if (item_mon.valid && item_mon.ready) begin
        pending_points.push_back(predict_point(cmd_e'(item_mon.cmd), item_mon.frame_count));
      end

      // anything still owed at the end is lost
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_points.size() != 0) begin
          $display("%0t: results outstanding, expected 0, actual %0d", $time,
                   pending_points.size());
          mismatch_count++;
        end
      end
    end
  end

endmodule

// ===== bench/galvo_raster_scan_generator_core_tb.sv =====
module galvo_raster_scan_generator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import grs_pkg::*;

  localparam int unsigned SendIdlePct[4] = '{0, 85, 0, 11};
  localparam int unsigned StallPct[4]    = '{0, 0, 85, 11};

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                run_done;
  int unsigned         mismatch_count;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned commands_sent;
  int unsigned points_taken;

  grs_item_if   item_if ();
  grs_result_if result_if ();

  galvo_raster_scan_generator_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_if),
    .result_o (result_if)
  );

  grs_point_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .item_mon       (item_if),
    .point_mon      (result_if),
    .run_done       (run_done),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL galvo_raster_scan_generator_core");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    result_if.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) points_taken++;
  end

  // one command transaction, with random idle cycles in front
  task automatic send_item(cmd_e cmd, frame_t frames);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.cmd         <= cmd;
    item_if.frame_count <= frames;
    do @(posedge clk_i); while (!(item_if.valid && item_if.ready));
    commands_sent++;
    @(negedge clk_i);
  endtask

  // hold the sender until every point owed has come back
  task automatic wait_drained();
    item_if.valid <= 1'b0;
    @(negedge clk_i);
    while (points_taken != commands_sent) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic apb_access(bit write, reg_idx_e idx, logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_config(cfg_t c);
    apb_access(1'b1, REG_X_START, ApbDataW'(c.x_start));
    apb_access(1'b1, REG_X_LIMIT, ApbDataW'(c.x_limit));
    apb_access(1'b1, REG_Y_START, ApbDataW'(c.y_start));
    apb_access(1'b1, REG_Y_LIMIT, ApbDataW'(c.y_limit));
    apb_access(1'b1, REG_X_INCREMENT, ApbDataW'(c.x_increment));
    apb_access(1'b1, REG_Y_INCREMENT, ApbDataW'(c.y_increment));
    apb_access(1'b1, REG_X_PHASE_BOUNDS, ApbDataW'(c.x_phase_bounds));
    apb_access(1'b1, REG_Y_PHASE_BOUNDS, ApbDataW'(c.y_phase_bounds));
    for (int i = 0; i < 8; i++) apb_access(1'b0, reg_idx_e'(i), '0);
  endtask

  // limit giving a chosen number of steps from the first position
  function automatic coord_t limit_for(coord_t first, coord_t inc, int unsigned steps);
    int unsigned lim;
    lim = first + inc * (steps + 1) - $urandom_range(inc - 1, 0);
    if (lim > 255) lim = 255;
    return coord_t'(lim);
  endfunction

  function automatic phase_bounds_t rand_phase_span();
    int unsigned lo;
    int unsigned hi;
    lo = ($urandom_range(3, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(8, 0);
    hi = lo + $urandom_range(1, 0);
    if (hi > 255) hi = 255;
    if ($urandom_range(9, 0) == 0) hi = $urandom_range(255, 0);
    return {coord_t'(hi), coord_t'(lo)};
  endfunction

  // mostly short scans so frames finish, with the register extremes now and then
  function automatic cfg_t rand_scan_config();
    cfg_t        c;
    int unsigned pick;
    pick = $urandom_range(11, 0);
    if (pick == 0) return '1;
    if (pick == 1) begin
      c             = '0;
      c.x_increment = 8'd1;
      c.y_increment = 8'd1;
      return c;
    end
    c.x_increment = ($urandom_range(3, 0) == 0) ? coord_t'($urandom_range(255, 1))
                                                : coord_t'($urandom_range(6, 1));
    c.y_increment = ($urandom_range(3, 0) == 0) ? coord_t'($urandom_range(255, 1))
                                                : coord_t'($urandom_range(6, 1));
    c.x_start = ($urandom_range(3, 0) == 0) ? coord_t'($urandom_range(255, 0))
                                            : coord_t'($urandom_range(20, 0));
    c.y_start = ($urandom_range(3, 0) == 0) ? coord_t'($urandom_range(255, 0))
                                            : coord_t'($urandom_range(20, 0));
    c.x_limit        = limit_for(c.x_start, c.x_increment, $urandom_range(4, 0));
    c.y_limit        = limit_for(c.y_start, c.y_increment, $urandom_range(4, 0));
    c.x_phase_bounds = rand_phase_span();
    c.y_phase_bounds = rand_phase_span();
    return c;
  endfunction

  function automatic frame_t rand_frame_count();
    int unsigned pick;
    pick = $urandom_range(19, 0);
    if (pick == 0) return '0;
    if (pick < 3) return frame_t'($urandom);
    return frame_t'($urandom_range(3, 1));
  endfunction

  initial begin
    cfg_t        c;
    int unsigned phase_no;
    int unsigned burst;

    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    run_done            = 1'b0;
    item_if.valid       = 1'b0;
    item_if.cmd         = CMD_TICK;
    item_if.frame_count = '0;
    result_if.ready     = 1'b0;
    send_idle_pct       = 0;
    stall_pct           = 0;
    commands_sent       = 0;
    points_taken        = 0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset registers: idle tick, empty start, long scan, restart while running
    send_item(CMD_TICK, '0);
    send_item(CMD_START, '0);
    send_item(CMD_TICK, '1);
    send_item(CMD_START, '1);
    repeat (3) send_item(CMD_TICK, '0);
    wait_drained();
    send_item(CMD_TICK, '0);
    send_item(CMD_START, 16'd1);
    repeat (2) send_item(CMD_TICK, '0);
    wait_drained();

    // two columns: x saturates, odd column mirrors below zero, one frame ends
    c = '{x_start: 8'd250, x_limit: 8'd253, y_start: 8'd0, y_limit: 8'd3,
          x_increment: 8'd1, y_increment: 8'd1,
          x_phase_bounds: 16'h0a0a, y_phase_bounds: 16'h0505};
    write_config(c);
    send_item(CMD_START, 16'd1);
    repeat (5) send_item(CMD_TICK, '0);
    wait_drained();

    // x phase range empty
    c.x_phase_bounds = 16'h0003;
    write_config(c);
    send_item(CMD_START, 16'd2);
    send_item(CMD_TICK, '0);
    wait_drained();

    // random phases, cycling the idle patterns
    phase_no = 0;
    while (commands_sent < 900) begin
      send_idle_pct = SendIdlePct[phase_no % 4];
      stall_pct     = StallPct[phase_no % 4];
      write_config(rand_scan_config());
      // skipping the start keeps an old scan going under new registers
      if ($urandom_range(4, 0) != 0) send_item(CMD_START, rand_frame_count());
      burst = $urandom_range(80, 10);
      repeat (burst) begin
        if ($urandom_range(29, 0) == 0) send_item(CMD_START, rand_frame_count());
        else send_item(CMD_TICK, frame_t'($urandom));
        if ($urandom_range(49, 0) == 0) wait_drained();
      end
      wait_drained();
      phase_no++;
    end

    repeat (4) @(negedge clk_i);
    run_done <= 1'b1;
    @(negedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS galvo_raster_scan_generator_core");
    end else begin
      $display("FAIL galvo_raster_scan_generator_core");
    end
    $finish;
  end

endmodule
